### rtl/core/huff_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package huff_pkg;

  // Default table depth and longest code
  localparam int unsigned SymbolCountDef = 128;
  localparam int unsigned MaxCodeBitsDef = 32;

  // Field widths fixed by the item format
  localparam int unsigned OpW    = 2;
  localparam int unsigned SymW   = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned LenW   = 6;
  localparam int unsigned ByteW  = 8;

  // Leftover bits (up to 7) plus the longest code word
  localparam int unsigned AccW   = ByteW - 1;
  localparam int unsigned BufW   = AccW + WordW;
  localparam int unsigned RemW   = $clog2(BufW + 1);

  // Operation codes
  localparam logic [OpW-1:0] OP_LOAD   = 2'd0;
  localparam logic [OpW-1:0] OP_ENCODE = 2'd1;
  localparam logic [OpW-1:0] OP_FLUSH  = 2'd2;

  // Work handed from the front end to the packing engine
  typedef enum logic {
    JOB_ENCODE,
    JOB_FLUSH
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [WordW-1:0] word;
    logic [LenW-1:0]  len;
  } job_t;

  // Input transaction payload
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [SymW-1:0]  symbol;
    logic [WordW-1:0] code_word;
    logic [LenW-1:0]  code_length;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_run;
  } out_item_t;

endpackage

### rtl/core/huff_front.sv
// Front end: accepts items, owns the code table and issues packing jobs.
module huff_front #(
  parameter int unsigned SymbolCount = huff_pkg::SymbolCountDef,
  parameter int unsigned MaxCodeBits = huff_pkg::MaxCodeBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  huff_pkg::in_item_t in_item_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output huff_pkg::job_t    job_o
);

  localparam int unsigned IdxW = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;

  // Code table storage; valid bits give the cleared-length reset view
  logic [huff_pkg::WordW-1:0] word_mem [SymbolCount];
  logic [huff_pkg::LenW-1:0]  len_mem  [SymbolCount];
  logic [SymbolCount-1:0]     vld_q;

  logic [huff_pkg::WordW-1:0] word_rd_q;
  logic [huff_pkg::LenW-1:0]  len_rd_q;
  logic                       vld_rd_q;

  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q;
  logic s1_drop, s1_advance, in_fire;
  logic in_range, is_load, is_encode, is_flush;
  logic [IdxW-1:0] idx;
  logic [huff_pkg::LenW-1:0] len_sat;

  // Decode the incoming item
  assign in_range  = {1'b0, in_item_i.symbol} < (huff_pkg::SymW + 1)'(SymbolCount);
  assign is_load   = in_item_i.operation == huff_pkg::OP_LOAD;
  assign is_encode = in_item_i.operation == huff_pkg::OP_ENCODE;
  assign is_flush  = in_item_i.operation == huff_pkg::OP_FLUSH;
  assign idx       = in_item_i.symbol[IdxW-1:0];
  assign len_sat   = (in_item_i.code_length > huff_pkg::LenW'(MaxCodeBits))
                   ? huff_pkg::LenW'(MaxCodeBits) : in_item_i.code_length;

  // Encode of an unused symbol produces no job
  assign s1_drop     = !s1_flush_q && (!vld_rd_q || (len_rd_q == '0));
  assign job_valid_o = s1_valid_q && !s1_drop;
  assign s1_advance  = !s1_valid_q || s1_drop || job_ready_i;
  assign in_ready_o  = s1_advance;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_valid_d  = (is_encode && in_range) || is_flush;

  assign job_o.kind = s1_flush_q ? huff_pkg::JOB_FLUSH : huff_pkg::JOB_ENCODE;
  assign job_o.word = word_rd_q;
  assign job_o.len  = len_rd_q;

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (in_fire && is_load && in_range) begin
      word_mem[idx] <= in_item_i.code_word;
      len_mem[idx]  <= len_sat;
    end
    if (in_fire) begin
      word_rd_q <= word_mem[idx];
      len_rd_q  <= len_mem[idx];
      vld_rd_q  <= vld_q[idx];
    end
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (in_fire && is_load && in_range) begin
      vld_q[idx] <= 1'b1;
    end
  end

  // Issue stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else if (s1_advance) begin
      s1_valid_q <= in_fire && s1_valid_d;
      s1_flush_q <= is_flush;
    end
  end

endmodule

### rtl/core/huff_queue.sv
// Two-entry job queue between the front end and the packing engine.
module huff_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  huff_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output huff_pkg::job_t pop_job_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  huff_pkg::job_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop)      cnt_q <= cnt_q + CntW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CntW'(1);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill level above depth");
`endif

endmodule

### rtl/core/huff_back.sv
// Packing engine: appends code bits and emits one byte per cycle while the output is not stalled.
module huff_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  huff_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output huff_pkg::out_item_t out_item_o
);

  localparam int unsigned BufW  = huff_pkg::BufW;
  localparam int unsigned RemW  = huff_pkg::RemW;
  localparam int unsigned AccW  = huff_pkg::AccW;
  localparam int unsigned ByteW = huff_pkg::ByteW;
  localparam int unsigned WordW = huff_pkg::WordW;

  logic [BufW-1:0]  bits_q, bits_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  huff_pkg::out_item_t out_q, out_d;

  logic             busy, slot_free, emit, pop, is_flush;
  logic [AccW-1:0]  acc;
  logic [WordW-1:0] word_masked;
  logic [3:0]       pad_shift;

  // Pending bits are the low rem_q bits when not busy
  assign busy      = rem_q >= RemW'(ByteW);
  assign slot_free = !out_valid_q || out_ready_i;
  assign is_flush  = job_i.kind == huff_pkg::JOB_FLUSH;
  assign acc       = bits_q[AccW-1:0] & ~({AccW{1'b1}} << rem_q[2:0]);
  assign word_masked = job_i.word & ~({WordW{1'b1}} << job_i.len);
  assign pad_shift = 4'(ByteW) - {1'b0, rem_q[2:0]};

  assign emit        = busy && slot_free;
  assign job_ready_o = !busy && (!is_flush || slot_free);
  assign pop         = job_valid_i && job_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Next-state logic
  always_comb begin
    bits_d      = bits_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = ByteW'(bits_q >> (rem_q - RemW'(ByteW)));
      out_d.last_of_run = rem_q < RemW'(2 * ByteW);
      rem_d             = rem_q - RemW'(ByteW);
    end else if (pop && is_flush) begin
      if (rem_q != '0) begin
        out_valid_d       = 1'b1;
        out_d.out_byte    = ByteW'({1'b0, acc} << pad_shift);
        out_d.last_of_run = 1'b1;
      end
      rem_d  = '0;
      bits_d = '0;
    end else if (pop) begin
      bits_d = (BufW'(acc) << job_i.len) | BufW'(word_masked);
      rem_d  = rem_q + RemW'(job_i.len);
    end
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= RemW'(BufW))
    else $error("bit buffer count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && out_d.last_of_run |=> rem_q < RemW'(ByteW))
    else $error("last byte of a run left a full byte behind");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> rem_q < RemW'(ByteW))
    else $error("job taken while bytes still pending");
`endif

endmodule

### rtl/core/huffman_code_bit_packer.sv
// Top level of the static Huffman encoder bit packer.
// Usage: items arrive on the in channel (valid/ready, in_item_i). A load item
// writes one code table entry, an encode item appends the symbol's code bits,
// and a flush item pads the leftover bits into a final byte. Packed bytes
// leave on the out channel (valid/ready, out_item_o), earliest bit in bit 7,
// with last_of_run set on the final byte an item produces.
// out_valid_o rises with the first byte of an encode once the item has passed
// the table read, the queue, the engine load and the output register. An
// encode occupies the packing engine for its load and then for each output
// byte (up to four), emitted one at a time by the single byte lane of the
// packing engine, which takes no new job while a full byte is pending; loads
// never reach the engine. A two-entry job queue sits between the table
// lookup and the packing engine so that lookups continue while bytes drain.
// Reset clears all table entries to length zero and empties the bit buffer;
// no clearing pass is needed, the table has a valid bit per entry.
// When the receiver stalls, the output register holds its byte, the engine
// stops, the queue fills, and then in_ready_o drops.
module huffman_code_bit_packer #(
  parameter int unsigned SymbolCount = huff_pkg::SymbolCountDef,
  parameter int unsigned MaxCodeBits = huff_pkg::MaxCodeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  huff_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output huff_pkg::out_item_t out_item_o
);

  logic           fe_valid, fe_ready, be_valid, be_ready;
  huff_pkg::job_t fe_job, be_job;

  huff_front #(
    .SymbolCount (SymbolCount),
    .MaxCodeBits (MaxCodeBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (fe_valid),
    .job_ready_i (fe_ready),
    .job_o       (fe_job)
  );

  huff_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_job_i   (fe_job),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_job_o    (be_job)
  );

  huff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (be_valid),
    .job_ready_o (be_ready),
    .job_i       (be_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
